// ===== sv/sep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sep_pkg
// Types and constants shared by the edge partitioner modules.
// ----------------------------------------------------------------------------
package sep_pkg;

   localparam int VERT_W     = 16;
   localparam int WORKER_W   = 4;
   localparam int GAMMA_W    = 36;
   localparam int SCALE_W    = 32;
   localparam int SHIFT_W    = 3;
   localparam int CNT_W      = 32;
   localparam int SCORE_W    = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 36;

   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_SCALE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_SCALE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_SHIFT  = 3'd3;

   localparam logic [GAMMA_W-1:0] GAMMA_RST        = 36'd0;
   localparam logic [SCALE_W-1:0] EDGE_SCALE_RST   = 32'd4294967;
   localparam logic [SCALE_W-1:0] VERTEX_SCALE_RST = 32'd1048576;
   localparam logic [SHIFT_W-1:0] GROUP_SHIFT_RST  = 3'd3;

   localparam logic signed [SCORE_W-1:0] ONE_FX   = 64'sh0000_0001_0000_0000;
   localparam logic [SCORE_W-1:0]        PROD_CAP = 64'h2000_0000_0000_0000;
   localparam logic [CNT_W-1:0]          CNT_MAX  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [VERT_W-1:0] vertex_u;
      logic [VERT_W-1:0] vertex_v;
   } req_type;

   typedef struct packed {
      logic [WORKER_W-1:0] worker;
      logic                new_u;
      logic                new_v;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/streaming_edge_partitioner_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// streaming_edge_partitioner_top
// Assigns each streamed edge to the best-scoring worker and tracks replicas.
//
//   channel | handshake          | payload
//   req     | req_valid/stall    | req_data  (vertex_u, vertex_v)
//   rsp     | rsp_valid/stall    | rsp_data  (worker, new_u, new_v)
//   csr     | csr_valid/ready    | csr_index, csr_data
//
// Per edge: read both bitmap rows, products, sum, compare tree, then
// write-back of the u row, then the v row, through the single memory write port.
// A one-entry input buffer takes the next edge while the current one runs.
// After reset a clearing pass zeroes every bitmap row; req takes
// one edge into the buffer and then stalls meanwhile, csr writes are taken.
// Result waits in an output register; while it is full and stalled the
// sequencer holds in the last write-back cycle.
// ----------------------------------------------------------------------------
module streaming_edge_partitioner_top import sep_pkg::*; #(
   parameter int WORKERS  = 16,
   parameter int VERTICES = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(VERTICES);
   localparam int LW = $clog2(WORKERS);
   localparam bit WRAP = (VERTICES <= 65536);
   localparam logic [31:0] RECIP =
      32'(((64'd1 << 32) + 64'(VERTICES) - 64'd1) / 64'(VERTICES));

   typedef enum logic [2:0] {
      S_CLR, S_RD, S_PROD, S_SUM, S_ARG, S_WRU, S_WRV
   } state_type;

   state_type state_ff;

   logic [GAMMA_W-1:0] gamma_ff;
   logic [SCALE_W-1:0] edge_scale_ff;
   logic [SCALE_W-1:0] vertex_scale_ff;
   logic [SHIFT_W-1:0] group_shift_ff;

   logic              buf_valid_ff;
   logic [VERT_W-1:0] buf_u_ff;
   logic [VERT_W-1:0] buf_v_ff;
   logic [VERT_W-1:0] buf_qu_ff;
   logic [VERT_W-1:0] buf_qv_ff;
   logic [47:0]       mul_u;
   logic [47:0]       mul_v;
   logic              take;
   logic [AW-1:0]     idx_u;
   logic [AW-1:0]     idx_v;

   logic [AW-1:0]     addr_u_ff;
   logic [AW-1:0]     addr_v_ff;
   logic [AW-1:0]     clr_addr_ff;

   logic [WORKERS-1:0] row_u;
   logic [WORKERS-1:0] row_v;
   logic [WORKERS-1:0] best_bit;
   logic [WORKERS-1:0] win_bit;
   logic [LW-1:0]      best;
   logic [LW-1:0]      win_ff;

   logic [WORKERS-1:0][CNT_W-1:0] edge_cnt_ff;
   logic [WORKERS-1:0][CNT_W-1:0] vtx_cnt_ff;

   logic              nu_ff;
   logic              nv_ff;
   logic              nu_in;
   logic              nv_in;
   logic [CNT_W:0]    vtx_sum;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [WORKERS-1:0] ram_wdata;
   logic               out_free;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff        <= GAMMA_RST;
         edge_scale_ff   <= EDGE_SCALE_RST;
         vertex_scale_ff <= VERTEX_SCALE_RST;
         group_shift_ff  <= GROUP_SHIFT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAMMA:        gamma_ff        <= csr_data[GAMMA_W-1:0];
            CSR_EDGE_SCALE:   edge_scale_ff   <= csr_data[SCALE_W-1:0];
            CSR_VERTEX_SCALE: vertex_scale_ff <= csr_data[SCALE_W-1:0];
            CSR_GROUP_SHIFT:  group_shift_ff  <= csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // input buffer with quotient for the index wrap
   assign req_stall = buf_valid_ff;
   assign take      = (state_ff == S_RD) && buf_valid_ff;
   assign mul_u     = 48'(req_data.vertex_u) * 48'(RECIP);
   assign mul_v     = 48'(req_data.vertex_v) * 48'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         buf_valid_ff <= 1'b1;
      end else if (take) begin
         buf_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         buf_u_ff  <= req_data.vertex_u;
         buf_v_ff  <= req_data.vertex_v;
         buf_qu_ff <= mul_u[47:32];
         buf_qv_ff <= mul_v[47:32];
      end
   end

   assign idx_u = WRAP ? AW'(33'(buf_u_ff) - 33'(buf_qu_ff) * 33'(VERTICES))
                       : AW'(buf_u_ff);
   assign idx_v = WRAP ? AW'(33'(buf_v_ff) - 33'(buf_qv_ff) * 33'(VERTICES))
                       : AW'(buf_v_ff);

   always_ff @(posedge clock) begin
      if (take) begin
         addr_u_ff <= idx_u;
         addr_v_ff <= idx_v;
      end
   end

   // bitmap memory
   assign best_bit = WORKERS'(1) << best;
   assign win_bit  = WORKERS'(1) << win_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_addr_ff;
      ram_wdata = '0;
      case (state_ff)
         S_CLR: begin
            ram_we = 1'b1;
         end
         S_WRU: begin
            ram_we    = 1'b1;
            ram_waddr = addr_u_ff;
            ram_wdata = row_u | best_bit;
         end
         S_WRV: begin
            ram_we    = 1'b1;
            ram_waddr = addr_v_ff;
            ram_wdata = row_v | win_bit;
         end
         default: ;
      endcase
   end

   sep_replica_ram #(
      .DEPTH (VERTICES),
      .WIDTH (WORKERS),
      .AW    (AW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_en     (take),
      .rd_addr_a (idx_u),
      .rd_addr_b (idx_v),
      .rd_data_a (row_u),
      .rd_data_b (row_v)
   );

   sep_lane_scorer #(
      .WORKERS (WORKERS),
      .LW      (LW)
   ) u_scorer (
      .clock        (clock),
      .row_u        (row_u),
      .row_v        (row_v),
      .edge_cnt     (edge_cnt_ff),
      .vtx_cnt      (vtx_cnt_ff),
      .gamma        (gamma_ff),
      .edge_scale   (edge_scale_ff),
      .vertex_scale (vertex_scale_ff),
      .group_shift  (group_shift_ff),
      .best         (best)
   );

   // counters
   assign nu_in   = !row_u[best];
   assign nv_in   = !row_v[best] && (addr_u_ff != addr_v_ff);
   assign vtx_sum = (CNT_W+1)'(vtx_cnt_ff[best]) + (CNT_W+1)'(nu_in)
                  + (CNT_W+1)'(nv_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WORKERS; w++) begin
            edge_cnt_ff[w] <= '0;
            vtx_cnt_ff[w]  <= '0;
         end
      end else if (state_ff == S_WRU) begin
         if (edge_cnt_ff[best] != CNT_MAX) begin
            edge_cnt_ff[best] <= edge_cnt_ff[best] + 32'd1;
         end
         vtx_cnt_ff[best] <= vtx_sum[CNT_W] ? CNT_MAX : vtx_sum[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WRU) begin
         nu_ff  <= nu_in;
         nv_ff  <= nv_in;
         win_ff <= best;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_WRV && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == AW'(VERTICES - 1)) begin
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               if (take) begin
                  state_ff <= S_PROD;
               end
            end
            S_PROD: state_ff <= S_SUM;
            S_SUM:  state_ff <= S_ARG;
            S_ARG:  state_ff <= S_WRU;
            S_WRU:  state_ff <= S_WRV;
            S_WRV: begin
               if (out_free) begin
                  rsp_ff.worker <= WORKER_W'(win_ff);
                  rsp_ff.new_u  <= nu_ff;
                  rsp_ff.new_v  <= nv_ff;
                  state_ff      <= S_RD;
               end
            end
            default: state_ff <= S_RD;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_read_before_score: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROD |-> $past(take))
      else $error("scoring started without a bitmap read");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRU |-> 32'(best) < 32'(WORKERS))
      else $error("winner index outside worker range");

   a_edge_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRU |=> (edge_cnt_ff[$past(best)]
         == $past(edge_cnt_ff[best]) + 32'd1)
         || (edge_cnt_ff[$past(best)] == CNT_MAX))
      else $error("edge count of winner did not advance");

   a_no_read_in_writeback: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRU || state_ff == S_WRV) |-> !take)
      else $error("bitmap read overlaps write-back");

endmodule
`default_nettype wire

// ===== sv/sep_replica_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sep_replica_ram
// Replica bitmap memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module sep_replica_ram #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 16,
   parameter int AW    = 16
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

// ===== sv/sep_lane_scorer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sep_lane_scorer
// Per-worker score lanes (products, sum) and a compare tree for the winner.
// ----------------------------------------------------------------------------
module sep_lane_scorer import sep_pkg::*; #(
   parameter int WORKERS = 16,
   parameter int LW      = 4
) (
   input  logic                           clock,
   input  logic [WORKERS-1:0]             row_u,
   input  logic [WORKERS-1:0]             row_v,
   input  logic [WORKERS-1:0][CNT_W-1:0]  edge_cnt,
   input  logic [WORKERS-1:0][CNT_W-1:0]  vtx_cnt,
   input  logic [GAMMA_W-1:0]             gamma,
   input  logic [SCALE_W-1:0]             edge_scale,
   input  logic [SCALE_W-1:0]             vertex_scale,
   input  logic [SHIFT_W-1:0]             group_shift,
   output logic [LW-1:0]                  best
);

   localparam int P = 1 << LW;

   logic signed [SCORE_W-1:0] end_ff  [0:WORKERS-1];
   logic signed [SCORE_W-1:0] end_in  [0:WORKERS-1];
   logic [SCORE_W-1:0]        pe_ff   [0:WORKERS-1];
   logic [SCORE_W-1:0]        pe_in   [0:WORKERS-1];
   logic [SCORE_W-1:0]        pv_ff   [0:WORKERS-1];
   logic [SCORE_W-1:0]        pv_in   [0:WORKERS-1];
   logic signed [SCORE_W-1:0] sc_ff   [0:WORKERS-1];
   logic signed [SCORE_W-1:0] sc_in   [0:WORKERS-1];
   logic signed [SCORE_W-1:0] tv      [0:2*P-1];
   logic [LW-1:0]             ti      [0:2*P-1];
   logic [LW-1:0]             best_ff;

   always_comb begin
      logic hit_u;
      logic hit_v;
      logic signed [SCORE_W-1:0] eu;
      logic signed [SCORE_W-1:0] ev;
      logic signed [SCORE_W-1:0] g;
      logic [SCORE_W-1:0] pe;
      logic [SCORE_W-1:0] pv;
      g = signed'(SCORE_W'(gamma));
      for (int w = 0; w < WORKERS; w++) begin
         hit_u = 1'b0;
         hit_v = 1'b0;
         for (int i = 0; i < WORKERS; i++) begin
            if (((7'(i) ^ 7'(w)) >> group_shift) == 7'd0) begin
               hit_u = hit_u | row_u[i];
               hit_v = hit_v | row_v[i];
            end
         end
         eu = '0;
         ev = '0;
         if (!row_u[w]) begin
            eu = (hit_u ? g : 64'sd0) - ONE_FX;
         end
         if (!row_v[w]) begin
            ev = (hit_v ? g : 64'sd0) - ONE_FX;
         end
         end_in[w] = eu + ev;
         pe = SCORE_W'(edge_cnt[w]) * SCORE_W'(edge_scale);
         pv = SCORE_W'(vtx_cnt[w]) * SCORE_W'(vertex_scale);
         pe_in[w] = (pe > PROD_CAP) ? PROD_CAP : pe;
         pv_in[w] = (pv > PROD_CAP) ? PROD_CAP : pv;
         sc_in[w] = end_ff[w] - signed'(pe_ff[w]) - signed'(pv_ff[w]);
      end
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < WORKERS; w++) begin
         end_ff[w] <= end_in[w];
         pe_ff[w]  <= pe_in[w];
         pv_ff[w]  <= pv_in[w];
         sc_ff[w]  <= sc_in[w];
      end
   end

   always_comb begin
      tv[0] = '0;
      ti[0] = '0;
      for (int n = 0; n < P; n++) begin
         if (n < WORKERS) begin
            tv[P+n] = sc_ff[n];
         end else begin
            tv[P+n] = {1'b1, {(SCORE_W-1){1'b0}}};
         end
         ti[P+n] = LW'(n);
      end
      for (int n = P - 1; n >= 1; n--) begin
         if (tv[2*n+1] > tv[2*n]) begin
            tv[n] = tv[2*n+1];
            ti[n] = ti[2*n+1];
         end else begin
            tv[n] = tv[2*n];
            ti[n] = ti[2*n];
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= ti[1];
   end

   assign best = best_ff;

endmodule
`default_nettype wire
